/* hw/rtl/trs_pkg.sv */
// Shared types and codes for the test-run sequencer with pulse counter.
// Used by trs_pulse, trs_seq and the top level; depends on nothing else.
package trs_pkg;

    localparam int unsigned HOLD_BITS = 26;
    localparam int unsigned WANT_BITS = 32;
    localparam int unsigned PMIN_BITS = 16;
    localparam int unsigned TOTAL_BITS = 32;
    localparam int unsigned CFG_DATA_BITS = 32;
    localparam int unsigned CFG_INDEX_BITS = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOOPS_WANTED = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PULSE_MIN = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PULSE_MAX = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RESET_HOLD = 2'd3;

    localparam logic [WANT_BITS-1:0] LOOPS_WANTED_RST = 32'd0;
    localparam logic [PMIN_BITS-1:0] PULSE_MIN_RST = 16'd990;
    localparam logic [PMIN_BITS-1:0] PULSE_MAX_RST = 16'd1010;
    localparam logic [HOLD_BITS-1:0] RESET_HOLD_RST = 26'd5000000;

    // Sequencer state codes.
    localparam logic [2:0] ST_STANDBY = 3'd0;
    localparam logic [2:0] ST_HEATING = 3'd1;
    localparam logic [2:0] ST_RUNNING = 3'd2;
    localparam logic [2:0] ST_PAUSED = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;
    localparam logic [2:0] ST_RESET = 3'd5;

    // Heater command codes.
    localparam logic [1:0] HEAT_NONE = 2'd0;
    localparam logic [1:0] HEAT_OFF = 2'd1;
    localparam logic [1:0] HEAT_REGULATE = 2'd2;

    // Program command codes.
    localparam logic [1:0] PROG_NONE = 2'd0;
    localparam logic [1:0] PROG_RUN = 2'd1;
    localparam logic [1:0] PROG_STOP = 2'd2;

    // Status from the pulse unit to the sequencer, after this tick's pin edges.
    typedef struct packed {
        logic reached;
        logic torque_pending;
    } t_pulse_stat;

    // Control from the sequencer back to the pulse unit.
    typedef struct packed {
        logic clear_count;
        logic torque_served;
    } t_seq_ctrl;

endpackage

/* hw/rtl/trs_pulse.sv */
// Loop pulse width measurement, qualified pulse counter and torque request latch.
// Depends on trs_pkg.
module trs_pulse import trs_pkg::*; #(
    parameter int unsigned COUNT_BITS = 32,
    parameter int unsigned WIDTH_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_loop_pin,
    input  logic                  i_torque_pin,
    input  logic [WANT_BITS-1:0]  i_loops_wanted,
    input  logic [PMIN_BITS-1:0]  i_pulse_min,
    input  logic [PMIN_BITS-1:0]  i_pulse_max,
    input  t_seq_ctrl             i_ctrl,
    output t_pulse_stat           o_stat,
    output logic [COUNT_BITS-1:0] o_count_next
);

    localparam int unsigned CMP_W = (WIDTH_BITS > PMIN_BITS) ? WIDTH_BITS : PMIN_BITS;
    localparam int unsigned CNT_W = (COUNT_BITS > WANT_BITS) ? COUNT_BITS : WANT_BITS;

    logic [WIDTH_BITS-1:0] r_width, n_width;
    logic [COUNT_BITS-1:0] r_count, n_count_upd;
    logic                  r_prev_loop, r_prev_torque, r_pending, n_pending_upd;
    logic                  width_ok;

    assign width_ok = (CMP_W'(r_width) >= CMP_W'(i_pulse_min))
                   && (CMP_W'(r_width) < CMP_W'(i_pulse_max));

    always_comb begin
        n_width = r_width;
        n_count_upd = r_count;
        if (i_loop_pin && !r_prev_loop) begin
            n_width = WIDTH_BITS'(1);
        end else if (i_loop_pin && r_prev_loop) begin
            if (r_width != '1) begin
                n_width = r_width + WIDTH_BITS'(1);
            end
        end else if (!i_loop_pin && r_prev_loop) begin
            if (width_ok && (r_count != '1)) begin
                n_count_upd = r_count + COUNT_BITS'(1);
            end
        end
        n_pending_upd = r_pending | (i_torque_pin & ~r_prev_torque);
    end

    assign o_stat.reached = CNT_W'(n_count_upd) >= CNT_W'(i_loops_wanted);
    assign o_stat.torque_pending = n_pending_upd;
    assign o_count_next = i_ctrl.clear_count ? '0 : n_count_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= '0;
            r_count <= '0;
            r_prev_loop <= 1'b0;
            r_prev_torque <= 1'b0;
            r_pending <= 1'b0;
        end else if (i_accept) begin
            r_width <= n_width;
            r_count <= o_count_next;
            r_prev_loop <= i_loop_pin;
            r_prev_torque <= i_torque_pin;
            r_pending <= n_pending_upd & ~i_ctrl.torque_served;
        end
    end

endmodule

/* hw/rtl/trs_seq.sv */
// Six-state test sequencer with the reset hold countdown and command decode.
// Depends on trs_pkg.
module trs_seq import trs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_run,
    input  logic                 i_rst_sw,
    input  logic                 i_below,
    input  logic [HOLD_BITS-1:0] i_hold_ticks,
    input  t_pulse_stat          i_stat,
    output t_seq_ctrl            o_ctrl,
    output logic [2:0]           o_state_next,
    output logic [1:0]           o_heat,
    output logic [1:0]           o_prog,
    output logic                 o_log,
    output logic                 o_read_torque,
    output logic                 o_changed
);

    logic [2:0]           r_state, n_state;
    logic [HOLD_BITS-1:0] r_hold, n_hold, hold_inc, need;

    // A hold time of zero behaves as one tick.
    assign need = (i_hold_ticks == '0) ? HOLD_BITS'(1) : i_hold_ticks;
    assign hold_inc = (r_hold < need) ? r_hold + HOLD_BITS'(1) : r_hold;

    always_comb begin
        n_state = r_state;
        n_hold = r_hold;
        o_heat = HEAT_NONE;
        o_prog = PROG_NONE;
        o_log = 1'b0;
        o_ctrl = '0;
        case (r_state)
            ST_STANDBY: begin
                if (i_run) begin
                    n_state = ST_HEATING;
                end else if (i_rst_sw) begin
                    n_state = ST_RESET;
                end else begin
                    o_heat = HEAT_OFF;
                end
            end
            ST_HEATING: begin
                o_heat = HEAT_REGULATE;
                if (!i_run) begin
                    n_state = ST_PAUSED;
                end else if (i_below) begin
                    o_prog = PROG_STOP;
                end else if (i_rst_sw) begin
                    n_state = ST_RESET;
                end else begin
                    n_state = ST_RUNNING;
                end
            end
            ST_RUNNING: begin
                o_prog = PROG_RUN;
                o_heat = HEAT_REGULATE;
                o_log = 1'b1;
                if (i_stat.reached) begin
                    n_state = ST_DONE;
                end else if (i_stat.torque_pending) begin
                    o_ctrl.torque_served = 1'b1;
                end else if (i_rst_sw) begin
                    n_state = ST_RESET;
                end
                // The run switch overrides every other exit.
                if (!i_run) begin
                    n_state = ST_PAUSED;
                end
            end
            ST_PAUSED: begin
                o_prog = PROG_STOP;
                o_heat = HEAT_OFF;
                if (i_run) begin
                    n_state = ST_HEATING;
                end else if (i_rst_sw) begin
                    n_state = ST_RESET;
                end
            end
            ST_DONE: begin
                if (i_rst_sw) begin
                    n_state = ST_RESET;
                end
            end
            ST_RESET: begin
                if (!i_rst_sw) begin
                    n_state = i_stat.reached ? ST_DONE : ST_PAUSED;
                end else begin
                    o_heat = HEAT_OFF;
                    o_prog = PROG_STOP;
                    n_hold = hold_inc;
                    if (hold_inc >= need) begin
                        o_ctrl.clear_count = 1'b1;
                        n_state = ST_STANDBY;
                    end
                end
            end
            default: begin
                n_state = ST_STANDBY;
            end
        endcase
        if (n_state != ST_RESET) begin
            n_hold = '0;
        end
    end

    assign o_state_next = n_state;
    assign o_read_torque = o_ctrl.torque_served;
    assign o_changed = (n_state != r_state);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_STANDBY;
            r_hold <= '0;
        end else if (i_accept) begin
            r_state <= n_state;
            r_hold <= n_hold;
        end
    end

endmodule

/* hw/rtl/test_run_sequencer_with_pulse_counter.sv */
// Results are registered: a result appears on the output in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; the result register accepts a new request
// in the same cycle that the held result is taken.
// Reset (synchronous, active low) returns to standby, clears all counters and
// latches, and restores the configuration registers to their default values.
// Top level of the test-run sequencer; depends on trs_pkg, trs_pulse and trs_seq.
module test_run_sequencer_with_pulse_counter import trs_pkg::*; #(
    parameter int unsigned COUNT_BITS = 32,
    parameter int unsigned WIDTH_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // [0] loop_pin, [1] torque_pin, [2] run_switch, [3] reset_switch,
    // [4] temp_below_setpoint, [7:5] zero
    input  logic [7:0]                i_s_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // [2:0] seq_state, [4:3] heater_cmd, [6:5] program_cmd, [7] log_data,
    // [8] read_torque, [9] status_event, [41:10] loop_total, [47:42] zero
    output logic [47:0]               o_m_axis_tdata,
    input  logic                      i_cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_wdata
);

    logic [WANT_BITS-1:0] r_loops_wanted;
    logic [PMIN_BITS-1:0] r_pulse_min, r_pulse_max;
    logic [HOLD_BITS-1:0] r_hold_ticks;

    logic                  s_accept;
    t_pulse_stat           stat;
    t_seq_ctrl             ctrl;
    logic [COUNT_BITS-1:0] count_next;
    logic [2:0]            state_next;
    logic [1:0]            heat, prog;
    logic                  log_d, rd_torque, changed;

    logic                  r_out_valid;
    logic [2:0]            r_out_state;
    logic [1:0]            r_out_heat, r_out_prog;
    logic                  r_out_log, r_out_rdt, r_out_evt;
    logic [TOTAL_BITS-1:0] r_out_total;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loops_wanted <= LOOPS_WANTED_RST;
            r_pulse_min <= PULSE_MIN_RST;
            r_pulse_max <= PULSE_MAX_RST;
            r_hold_ticks <= RESET_HOLD_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_LOOPS_WANTED: r_loops_wanted <= i_cfg_wdata[WANT_BITS-1:0];
                CFG_PULSE_MIN:    r_pulse_min <= i_cfg_wdata[PMIN_BITS-1:0];
                CFG_PULSE_MAX:    r_pulse_max <= i_cfg_wdata[PMIN_BITS-1:0];
                CFG_RESET_HOLD:   r_hold_ticks <= i_cfg_wdata[HOLD_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    trs_pulse #(
        .COUNT_BITS(COUNT_BITS),
        .WIDTH_BITS(WIDTH_BITS)
    ) u_pulse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (s_accept),
        .i_loop_pin    (i_s_axis_tdata[0]),
        .i_torque_pin  (i_s_axis_tdata[1]),
        .i_loops_wanted(r_loops_wanted),
        .i_pulse_min   (r_pulse_min),
        .i_pulse_max   (r_pulse_max),
        .i_ctrl        (ctrl),
        .o_stat        (stat),
        .o_count_next  (count_next)
    );

    trs_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (s_accept),
        .i_run        (i_s_axis_tdata[2]),
        .i_rst_sw     (i_s_axis_tdata[3]),
        .i_below      (i_s_axis_tdata[4]),
        .i_hold_ticks (r_hold_ticks),
        .i_stat       (stat),
        .o_ctrl       (ctrl),
        .o_state_next (state_next),
        .o_heat       (heat),
        .o_prog       (prog),
        .o_log        (log_d),
        .o_read_torque(rd_torque),
        .o_changed    (changed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out_state <= state_next;
            r_out_heat <= heat;
            r_out_prog <= prog;
            r_out_log <= log_d;
            r_out_rdt <= rd_torque;
            r_out_evt <= changed;
            r_out_total <= TOTAL_BITS'(count_next);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata = {6'd0, r_out_total, r_out_evt, r_out_rdt, r_out_log,
                             r_out_prog, r_out_heat, r_out_state};

    // A request is never taken while an untaken result would be overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_accept && r_out_valid && !i_m_axis_tready))
        else $error("request accepted over a held result");

    // Data logging goes with the run program command; both come only from running.
    a_log_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_log == (r_out_prog == PROG_RUN)))
        else $error("log_data and run program disagree");

    // A served torque request happens only in the running state and clears the latch.
    a_torque_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && rd_torque) |-> (heat == HEAT_REGULATE && prog == PROG_RUN
                                      && stat.torque_pending))
        else $error("torque served outside running state");

endmodule

/* tb/tb_test_run_sequencer_with_pulse_counter.sv */
// Self-checking testbench for the test-run sequencer with loop pulse counter.
// Drives pin ticks over the input stream and checks every result tick against a
// cycle-level predictor. Depends on trs_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_test_run_sequencer_with_pulse_counter;
    import trs_pkg::*;

    localparam int unsigned RUN_LIMIT = 1_000_000;
    localparam int unsigned RANDOM_TICKS = 155;
    localparam int unsigned LONG_PULSE_TICKS = 40;

    // Pin sample of one tick, loop_pin in bit 0.
    typedef struct packed {
        logic temp_below;
        logic reset_sw;
        logic run_sw;
        logic torque_pin;
        logic loop_pin;
    } t_pins;

    // Result tick, seq_state in the lowest bits.
    typedef struct packed {
        logic [TOTAL_BITS-1:0] loop_total;
        logic                  status_event;
        logic                  read_torque;
        logic                  log_data;
        logic [1:0]            program_cmd;
        logic [1:0]            heater_cmd;
        logic [2:0]            seq_state;
    } t_outs;

    class seq_tick_checker;
        logic [WANT_BITS-1:0]  loops_wanted;
        logic [PMIN_BITS-1:0]  pulse_min;
        logic [PMIN_BITS-1:0]  pulse_max;
        logic [HOLD_BITS-1:0]  hold_ticks;

        logic [2:0]            state;
        logic [TOTAL_BITS-1:0] loop_count;
        logic [PMIN_BITS-1:0]  pulse_width;
        logic                  prev_loop;
        logic                  prev_torque;
        logic                  torque_latched;
        logic [HOLD_BITS-1:0]  hold_count;

        t_outs expected_outs[$];
        int unsigned errors;
        int unsigned ticks_checked;
        int unsigned pulses_counted;
        int unsigned torque_reads;
        int unsigned resets_done;
        logic [7:0]  states_seen;

        function new();
            loops_wanted = LOOPS_WANTED_RST;
            pulse_min = PULSE_MIN_RST;
            pulse_max = PULSE_MAX_RST;
            hold_ticks = RESET_HOLD_RST;
            state = ST_STANDBY;
            loop_count = '0;
            pulse_width = '0;
            prev_loop = 1'b0;
            prev_torque = 1'b0;
            torque_latched = 1'b0;
            hold_count = '0;
            states_seen = 8'h01;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] value);
            case (index)
                CFG_LOOPS_WANTED: loops_wanted = value[WANT_BITS-1:0];
                CFG_PULSE_MIN:    pulse_min = value[PMIN_BITS-1:0];
                CFG_PULSE_MAX:    pulse_max = value[PMIN_BITS-1:0];
                CFG_RESET_HOLD:   hold_ticks = value[HOLD_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_outs.size();
        endfunction

        task report(string what);
            if (errors < 40)
                $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        // One tick: pulse width and torque edge first, then one sequencer step.
        function t_outs step_sequencer(t_pins p);
            t_outs o;
            logic [2:0] nxt;
            logic reached;
            logic [HOLD_BITS-1:0] need;
            o = '0;
            if (p.loop_pin && !prev_loop) begin
                pulse_width = PMIN_BITS'(1);
            end else if (p.loop_pin && prev_loop) begin
                if (pulse_width != '1) pulse_width++;
            end else if (!p.loop_pin && prev_loop) begin
                if (pulse_width >= pulse_min && pulse_width < pulse_max && loop_count != '1) begin
                    loop_count++;
                    pulses_counted++;
                end
            end
            prev_loop = p.loop_pin;
            if (p.torque_pin && !prev_torque) torque_latched = 1'b1;
            prev_torque = p.torque_pin;

            reached = (loop_count >= loops_wanted);
            nxt = state;
            case (state)
                ST_STANDBY: begin
                    if (p.run_sw) nxt = ST_HEATING;
                    else if (p.reset_sw) nxt = ST_RESET;
                    else o.heater_cmd = HEAT_OFF;
                end
                ST_HEATING: begin
                    o.heater_cmd = HEAT_REGULATE;
                    if (!p.run_sw) nxt = ST_PAUSED;
                    else if (p.temp_below) o.program_cmd = PROG_STOP;
                    else if (p.reset_sw) nxt = ST_RESET;
                    else nxt = ST_RUNNING;
                end
                ST_RUNNING: begin
                    o.program_cmd = PROG_RUN;
                    o.heater_cmd = HEAT_REGULATE;
                    o.log_data = 1'b1;
                    if (reached) begin
                        nxt = ST_DONE;
                    end else if (torque_latched) begin
                        torque_latched = 1'b0;
                        o.read_torque = 1'b1;
                        torque_reads++;
                    end else if (p.reset_sw) begin
                        nxt = ST_RESET;
                    end
                    // A run switch turned off wins over every other exit.
                    if (!p.run_sw) nxt = ST_PAUSED;
                end
                ST_PAUSED: begin
                    o.program_cmd = PROG_STOP;
                    o.heater_cmd = HEAT_OFF;
                    if (p.run_sw) nxt = ST_HEATING;
                    else if (p.reset_sw) nxt = ST_RESET;
                end
                ST_DONE: begin
                    if (p.reset_sw) nxt = ST_RESET;
                end
                ST_RESET: begin
                    if (!p.reset_sw) begin
                        nxt = reached ? ST_DONE : ST_PAUSED;
                    end else begin
                        o.heater_cmd = HEAT_OFF;
                        o.program_cmd = PROG_STOP;
                        need = (hold_ticks == '0) ? HOLD_BITS'(1) : hold_ticks;
                        if (hold_count < need) hold_count++;
                        if (hold_count >= need) begin
                            loop_count = '0;
                            nxt = ST_STANDBY;
                            resets_done++;
                        end
                    end
                end
                default: nxt = ST_STANDBY;
            endcase
            o.status_event = (nxt != state);
            state = nxt;
            if (state != ST_RESET) hold_count = '0;
            states_seen[state] = 1'b1;
            o.seq_state = state;
            o.loop_total = loop_count;
            return o;
        endfunction

        function void note_tick(t_pins p);
            expected_outs.push_back(step_sequencer(p));
        endfunction

        task check_outputs(t_outs got);
            t_outs want;
            if (expected_outs.size() == 0) begin
                report("result tick with no request outstanding");
                return;
            end
            want = expected_outs.pop_front();
            if (got.seq_state !== want.seq_state)
                report($sformatf("tick %0d seq_state %0d, want %0d",
                                 ticks_checked, got.seq_state, want.seq_state));
            if (got.heater_cmd !== want.heater_cmd)
                report($sformatf("tick %0d heater_cmd %0d, want %0d",
                                 ticks_checked, got.heater_cmd, want.heater_cmd));
            if (got.program_cmd !== want.program_cmd)
                report($sformatf("tick %0d program_cmd %0d, want %0d",
                                 ticks_checked, got.program_cmd, want.program_cmd));
            if (got.log_data !== want.log_data)
                report($sformatf("tick %0d log_data %0b, want %0b",
                                 ticks_checked, got.log_data, want.log_data));
            if (got.read_torque !== want.read_torque)
                report($sformatf("tick %0d read_torque %0b, want %0b",
                                 ticks_checked, got.read_torque, want.read_torque));
            if (got.status_event !== want.status_event)
                report($sformatf("tick %0d status_event %0b, want %0b",
                                 ticks_checked, got.status_event, want.status_event));
            if (got.loop_total !== want.loop_total)
                report($sformatf("tick %0d loop_total %0d, want %0d",
                                 ticks_checked, got.loop_total, want.loop_total));
            ticks_checked++;
        endtask
    endclass

    // Directed ticks, written as {temp_below, reset_sw, run_sw, torque_pin, loop_pin}.
    // Meant for loops_wanted 2, pulse window [2, 4) and a hold of 2 ticks.
    localparam logic [4:0] DIRECTED_TICKS [26] = '{
        5'b00000, 5'b01000, 5'b00000, 5'b00100, 5'b10100, 5'b01100, 5'b01000,
        5'b01000, 5'b00100, 5'b00000, 5'b00100, 5'b00100, 5'b00101, 5'b00101,
        5'b00110, 5'b00111, 5'b00101, 5'b00101, 5'b00101, 5'b01100, 5'b00000,
        5'b00100, 5'b00101, 5'b00101, 5'b00000, 5'b11111
    };

    logic                      i_clk;
    logic                      i_rst_n = 1'b0;
    logic                      i_s_axis_tvalid = 1'b0;
    logic                      o_s_axis_tready;
    logic [7:0]                i_s_axis_tdata = '0;
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready = 1'b0;
    logic [47:0]               o_m_axis_tdata;
    logic                      i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_wdata = '0;

    seq_tick_checker sb = new();
    int unsigned cycles = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;

    // Pin pattern state for the random part.
    logic loop_level = 1'b0;
    logic torque_level = 1'b0;
    int   loop_left = 0;
    int   run_off_left = 0;
    int   reset_left = 0;

    test_run_sequencer_with_pulse_counter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_tick(t_pins'(i_s_axis_tdata[4:0]));
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_outputs(t_outs'(o_m_axis_tdata[41:0]));
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("tb_test_run_sequencer_with_pulse_counter: FAIL");
            $finish;
        end
    end

    task automatic send_tick(t_pins p);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {3'b000, p};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_ticks(t_pins p, int unsigned n);
        repeat (n) send_tick(p);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Only called with nothing in flight; the enable drops on the next falling edge.
    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.write_reg(index, value);
    endtask

    task automatic write_all_regs(logic [31:0] want, logic [15:0] pmin, logic [15:0] pmax,
                                  logic [25:0] hold);
        write_reg(CFG_LOOPS_WANTED, want);
        write_reg(CFG_PULSE_MIN, pmin);
        write_reg(CFG_PULSE_MAX, pmax);
        write_reg(CFG_RESET_HOLD, hold);
    endtask

    // Mostly plausible operation: run held on, pulses around the width window,
    // reset presses near the hold length. About one tick in ten is pure noise.
    task automatic make_random_tick(output t_pins p);
        int lo;
        int hi;
        int press_max;
        if ($urandom_range(9) == 0) begin
            p = t_pins'(5'($urandom_range(31)));
            return;
        end
        if (loop_left == 0) begin
            loop_level = !loop_level;
            if (loop_level) begin
                if (sb.pulse_min <= 40 && sb.pulse_max <= 40 && sb.pulse_min < sb.pulse_max) begin
                    lo = (sb.pulse_min > 1) ? sb.pulse_min - 1 : 1;
                    hi = sb.pulse_max + 1;
                end else begin
                    lo = 1;
                    hi = 8;
                end
                loop_left = $urandom_range(hi, lo);
            end else begin
                loop_left = $urandom_range(4, 1);
            end
        end
        loop_left--;
        if ($urandom_range(7) == 0) torque_level = !torque_level;
        if (run_off_left > 0) run_off_left--;
        else if ($urandom_range(39) == 0) run_off_left = $urandom_range(6, 1);
        press_max = ((sb.hold_ticks > 16) ? 16 : sb.hold_ticks) + 3;
        if (reset_left > 0) reset_left--;
        else if ($urandom_range(29) == 0) reset_left = $urandom_range(press_max, 1);
        p.loop_pin = loop_level;
        p.torque_pin = torque_level;
        p.run_sw = (run_off_left == 0);
        p.reset_sw = (reset_left > 0);
        p.temp_below = ($urandom_range(4) == 0);
    endtask

    task automatic run_phase(int unsigned src_pct, int unsigned sink_pct, logic [31:0] want,
                             logic [15:0] pmin, logic [15:0] pmax, logic [25:0] hold);
        t_pins p;
        wait_drained();
        write_all_regs(want, pmin, pmax, hold);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < RANDOM_TICKS; i++) begin
            // Halfway through, hold the sender until every result is back.
            if (i == RANDOM_TICKS / 2) wait_drained();
            make_random_tick(p);
            send_tick(p);
        end
    endtask

    initial begin
        t_pins p;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_all_regs(32'd2, 16'd2, 16'd4, 26'd2);
        foreach (DIRECTED_TICKS[i]) send_tick(t_pins'(DIRECTED_TICKS[i]));
        wait_drained();

        // With the widest window a long pulse and a short one both count. The
        // reset press then never completes because the hold is at its maximum.
        write_all_regs(32'd3, 16'd0, 16'hFFFF, 26'h3FF_FFFF);
        p = '0;
        p.run_sw = 1'b1;
        send_ticks(p, 2);
        p.loop_pin = 1'b1;
        send_ticks(p, LONG_PULSE_TICKS);
        p.loop_pin = 1'b0;
        send_tick(p);
        p.loop_pin = 1'b1;
        send_ticks(p, 3);
        p.loop_pin = 1'b0;
        send_ticks(p, 2);
        p.reset_sw = 1'b1;
        send_ticks(p, 6);
        p.reset_sw = 1'b0;
        send_ticks(p, 2);

        run_phase(0, 0, 32'd5, 16'd2, 16'd5, 26'd4);
        run_phase(81, 0, 32'd0, 16'hFFFF, 16'd0, 26'd1);
        run_phase(0, 81, 32'hFFFF_FFFF, 16'd3, 16'hFFFF, 26'd0);
        run_phase(34, 34, 32'd12, 16'd1, 16'd4, 26'd6);

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));

        $display("Checked %0d ticks over six settings: %0d qualified pulses, %0d torque reads,",
                 sb.ticks_checked, sb.pulses_counted, sb.torque_reads);
        $display("%0d completed resets, state set %b, %0d mismatches.",
                 sb.resets_done, sb.states_seen[5:0], sb.errors);
        if (sb.errors == 0) begin
            $display("tb_test_run_sequencer_with_pulse_counter: PASS");
        end else begin
            $display("tb_test_run_sequencer_with_pulse_counter: FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/trs_pkg.sv
hw/rtl/trs_pulse.sv
hw/rtl/trs_seq.sv
hw/rtl/test_run_sequencer_with_pulse_counter.sv
tb/tb_test_run_sequencer_with_pulse_counter.sv
